### sv/rsd_pkg.sv
// ---------------------------------------------------------------------------
// rsd_pkg: shared types and constants of the rank subdomain decomposer
// Field widths, queue sizes, register indexes and the divider step function.
// ---------------------------------------------------------------------------
`default_nettype none

package rsd_pkg;

	// field widths
	localparam int RankW = 16;
	localparam int DensW = 4;
	localparam int PtsW  = 12;
	localparam int ProcW = 9;
	localparam int SizeW = 15;
	localparam int CfgIdxW = 3;
	localparam int CfgW  = 12;

	// stream widths
	localparam int InDataW  = 24;
	localparam int OutDataW = 192;
	localparam int ResW     = 6 * RankW + 6 * SizeW;

	// register indexes
	localparam logic [CfgIdxW-1:0] CFG_GPX = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_GPY = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_GPZ = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_PX  = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_PY  = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_PZ  = 3'd5;

	// divider pipeline: two quotient bits per stage
	localparam int DivStages = 8;

	// queue between front and back
	localparam int QDepth = 32;
	localparam int QAw    = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	// result buffer of the back part
	localparam int OutDepth = 8;
	localparam int OutAw    = $clog2(OutDepth);
	localparam int OutCntW  = $clog2(OutDepth + 1);

	// effective configuration, processor counts already forced nonzero
	typedef struct packed {
		logic [PtsW-1:0]  npx;
		logic [PtsW-1:0]  npy;
		logic [PtsW-1:0]  npz;
		logic [ProcW-1:0] px;
		logic [ProcW-1:0] py;
		logic [ProcW-1:0] pz;
	} cfg_t;

	// one classified item handed from front to back
	typedef struct packed {
		logic [RankW-1:0] x;
		logic [ProcW-1:0] xm;
		logic [ProcW-1:0] y;
		logic [ProcW-1:0] z;
		logic [DensW-1:0] d;
		logic [PtsW-1:0]  qx;
		logic [PtsW-1:0]  qy;
		logic [PtsW-1:0]  qz;
		logic [ProcW-1:0] rx;
		logic [ProcW-1:0] ry;
		logic [ProcW-1:0] rz;
	} coord_t;

	// one result, last member in the lowest bits
	typedef struct packed {
		logic [SizeW-1:0] offset_z;
		logic [SizeW-1:0] offset_y;
		logic [SizeW-1:0] offset_x;
		logic [SizeW-1:0] local_size_z;
		logic [SizeW-1:0] local_size_y;
		logic [SizeW-1:0] local_size_x;
		logic [RankW-1:0] down_rank;
		logic [RankW-1:0] up_rank;
		logic [RankW-1:0] west_rank;
		logic [RankW-1:0] east_rank;
		logic [RankW-1:0] south_rank;
		logic [RankW-1:0] north_rank;
	} result_t;

	// one restoring division step: returns {quotient bit, new remainder}
	function automatic logic [ProcW:0] div_step(input logic [ProcW-1:0] rem,
		input logic nb, input logic [ProcW-1:0] dv);
		logic [ProcW:0] t;
		logic [ProcW:0] diff;
		t = {rem, nb};
		diff = t - {1'b0, dv};
		if (t >= {1'b0, dv}) begin
			div_step = {1'b1, diff[ProcW-1:0]};
		end else begin
			div_step = {1'b0, t[ProcW-1:0]};
		end
	endfunction

endpackage

`default_nettype wire

### sv/rsd_div.sv
// ---------------------------------------------------------------------------
// rsd_div: pipelined 16 by 9 bit unsigned divider
// Restoring division, two quotient bits per stage, fixed latency, no stall.
// ---------------------------------------------------------------------------
`default_nettype none

module rsd_div (
	input  wire logic                          clk,
	input  wire logic [rsd_pkg::RankW-1:0]     num,
	input  wire logic [rsd_pkg::ProcW-1:0]     dv,
	output logic      [rsd_pkg::RankW-1:0]     quo,
	output logic      [rsd_pkg::ProcW-1:0]     rem
);

	logic [rsd_pkg::RankW-1:0] num_s [rsd_pkg::DivStages];
	logic [rsd_pkg::ProcW-1:0] rem_s [rsd_pkg::DivStages];
	logic [rsd_pkg::ProcW-1:0] dv_s  [rsd_pkg::DivStages];

	for (genvar k = 0; k < rsd_pkg::DivStages; k++) begin : g_st
		logic [rsd_pkg::RankW-1:0] n_in;
		logic [rsd_pkg::ProcW-1:0] r_in;
		logic [rsd_pkg::ProcW-1:0] d_in;
		logic [rsd_pkg::ProcW:0]   st1;
		logic [rsd_pkg::ProcW:0]   st2;

		// stage inputs
		if (k == 0) begin : g_first
			assign n_in = num;
			assign r_in = '0;
			assign d_in = dv;
		end else begin : g_next
			assign n_in = num_s[k-1];
			assign r_in = rem_s[k-1];
			assign d_in = dv_s[k-1];
		end

		// two dependent steps on the top dividend bits
		always_comb begin
			st1 = rsd_pkg::div_step(r_in, n_in[rsd_pkg::RankW-1], d_in);
			st2 = rsd_pkg::div_step(st1[rsd_pkg::ProcW-1:0], n_in[rsd_pkg::RankW-2], d_in);
		end

		// quotient bits shift in at the bottom
		always_ff @(posedge clk) begin
			num_s[k] <= {n_in[rsd_pkg::RankW-3:0], st1[rsd_pkg::ProcW], st2[rsd_pkg::ProcW]};
			rem_s[k] <= st2[rsd_pkg::ProcW-1:0];
			dv_s[k]  <= d_in;
		end
	end

	assign quo = num_s[rsd_pkg::DivStages-1];
	assign rem = rem_s[rsd_pkg::DivStages-1];

endmodule

`default_nettype wire

### sv/rsd_front.sv
// ---------------------------------------------------------------------------
// rsd_front: rank classification
// Splits a rank into z, y, x through three chained divider pipelines, folds
// x, and divides the grid point counts; admits beats by queue credit.
// ---------------------------------------------------------------------------
`default_nettype none

module rsd_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire rsd_pkg::cfg_t               cfg,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [rsd_pkg::RankW-1:0]   in_rank,
	input  wire logic [rsd_pkg::DensW-1:0]   in_dens,
	output logic                             push,
	output rsd_pkg::coord_t                  push_item,
	input  wire logic                        pop
);

	localparam int L = rsd_pkg::DivStages - 1;

	logic                       acc;
	logic [rsd_pkg::QCntW-1:0]  occ_q;

	logic [rsd_pkg::DivStages-1:0] v1_s, v2_s, v3_s;
	logic [rsd_pkg::DensW-1:0] d1_s  [rsd_pkg::DivStages];
	logic [rsd_pkg::DensW-1:0] d2_s  [rsd_pkg::DivStages];
	logic [rsd_pkg::ProcW-1:0] z2_s  [rsd_pkg::DivStages];
	logic [rsd_pkg::DensW-1:0] d3_s  [rsd_pkg::DivStages];
	logic [rsd_pkg::ProcW-1:0] z3_s  [rsd_pkg::DivStages];
	logic [rsd_pkg::ProcW-1:0] y3_s  [rsd_pkg::DivStages];
	logic [rsd_pkg::RankW-1:0] xf3_s [rsd_pkg::DivStages];

	logic [rsd_pkg::RankW-1:0] quo1, quo2, quo3, qnx, qny, qnz;
	logic [rsd_pkg::ProcW-1:0] rem1, rem2, rem3, rnx, rny, rnz;
	logic [rsd_pkg::RankW-1:0] xa, xf;

	// credit: items admitted and not yet taken by the back part
	assign in_ready = (occ_q < rsd_pkg::QCntW'(rsd_pkg::QDepth));
	assign acc = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + rsd_pkg::QCntW'(acc) - rsd_pkg::QCntW'(pop);
		end
	end

	// z = rank % pz, t = rank / pz
	rsd_div u_div1 (.clk(clk), .num(in_rank), .dv(cfg.pz), .quo(quo1), .rem(rem1));
	// y = t % py, x = t / py
	rsd_div u_div2 (.clk(clk), .num(quo1), .dv(cfg.py), .quo(quo2), .rem(rem2));

	// fold x down by px at most twice
	always_comb begin
		xa = quo2;
		if (xa >= rsd_pkg::RankW'(cfg.px)) begin
			xa = xa - rsd_pkg::RankW'(cfg.px);
		end
		xf = xa;
		if (xf >= rsd_pkg::RankW'(cfg.px)) begin
			xf = xf - rsd_pkg::RankW'(cfg.px);
		end
	end

	// x % px for the wrapped east and west neighbors, and grid shares
	rsd_div u_div3 (.clk(clk), .num(quo2), .dv(cfg.px), .quo(quo3), .rem(rem3));
	rsd_div u_divnx (.clk(clk), .num(rsd_pkg::RankW'(cfg.npx)), .dv(cfg.px),
		.quo(qnx), .rem(rnx));
	rsd_div u_divny (.clk(clk), .num(rsd_pkg::RankW'(cfg.npy)), .dv(cfg.py),
		.quo(qny), .rem(rny));
	rsd_div u_divnz (.clk(clk), .num(rsd_pkg::RankW'(cfg.npz)), .dv(cfg.pz),
		.quo(qnz), .rem(rnz));

	// valid bits along the three divider phases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s <= '0;
			v2_s <= '0;
			v3_s <= '0;
		end else begin
			v1_s <= {v1_s[L-1:0], acc};
			v2_s <= {v2_s[L-1:0], v1_s[L]};
			v3_s <= {v3_s[L-1:0], v2_s[L]};
		end
	end

	// side data riding next to the dividers
	always_ff @(posedge clk) begin
		d1_s[0]  <= in_dens;
		d2_s[0]  <= d1_s[L];
		z2_s[0]  <= rem1;
		d3_s[0]  <= d2_s[L];
		z3_s[0]  <= z2_s[L];
		y3_s[0]  <= rem2;
		xf3_s[0] <= xf;
		for (int i = 1; i < rsd_pkg::DivStages; i++) begin
			d1_s[i]  <= d1_s[i-1];
			d2_s[i]  <= d2_s[i-1];
			z2_s[i]  <= z2_s[i-1];
			d3_s[i]  <= d3_s[i-1];
			z3_s[i]  <= z3_s[i-1];
			y3_s[i]  <= y3_s[i-1];
			xf3_s[i] <= xf3_s[i-1];
		end
	end

	// hand-off to the queue
	assign push = v3_s[L];
	always_comb begin
		push_item.x  = xf3_s[L];
		push_item.xm = rem3;
		push_item.y  = y3_s[L];
		push_item.z  = z3_s[L];
		push_item.d  = d3_s[L];
		push_item.qx = qnx[rsd_pkg::PtsW-1:0];
		push_item.qy = qny[rsd_pkg::PtsW-1:0];
		push_item.qz = qnz[rsd_pkg::PtsW-1:0];
		push_item.rx = rnx;
		push_item.ry = rny;
		push_item.rz = rnz;
	end

	// quo3 is unused; only the remainder of u_div3 is taken
	logic unused_quo3;
	assign unused_quo3 = ^quo3;

`ifndef ASSERT_OFF
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= rsd_pkg::QCntW'(rsd_pkg::QDepth))
		else $error("front credit count above queue depth");
`endif

endmodule

`default_nettype wire

### sv/rsd_queue.sv
// ---------------------------------------------------------------------------
// rsd_queue: item queue between front and back
// Flop-based FIFO of classified items, head shown without delay.
// ---------------------------------------------------------------------------
`default_nettype none

module rsd_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire rsd_pkg::coord_t   push_item,
	output logic                   head_valid,
	output rsd_pkg::coord_t        head_item,
	input  wire logic              pop
);

	rsd_pkg::coord_t mem_q [rsd_pkg::QDepth];
	logic [rsd_pkg::QAw-1:0]   wp_q, rp_q;
	logic [rsd_pkg::QCntW-1:0] cnt_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_item;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + rsd_pkg::QCntW'(push) - rsd_pkg::QCntW'(pop);
		end
	end

	assign head_valid = (cnt_q != '0);
	assign head_item  = mem_q[rp_q];

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q < rsd_pkg::QCntW'(rsd_pkg::QDepth)) || pop)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

### sv/rsd_back.sv
// ---------------------------------------------------------------------------
// rsd_back: neighbor ranks and subdomain shares
// Four-stage arithmetic pipeline and a result buffer toward the stream.
// ---------------------------------------------------------------------------
`default_nettype none

module rsd_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire rsd_pkg::cfg_t                  cfg,
	input  wire logic                           in_valid,
	input  wire rsd_pkg::coord_t                in_item,
	output logic                                in_pop,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	output logic [rsd_pkg::OutDataW-1:0]        m_axis_tdata
);

	localparam int RW = rsd_pkg::RankW;
	localparam int PW = rsd_pkg::ProcW;
	localparam int SW = rsd_pkg::SizeW;
	localparam int NW = rsd_pkg::PtsW;
	localparam int DW = rsd_pkg::DensW;

	logic [rsd_pkg::OutCntW-1:0] bocc_q;
	logic deliver;
	logic v_s1, v_s2, v_s3, v_s4;

	// stage 1
	logic [RW-1:0] x_s1;
	logic [PW-1:0] y_s1, z_s1, yn_s1, ys_s1, zu_s1, zd_s1, xe_s1, xw_s1;
	logic [PW-1:0] ex_s1, ey_s1, ez_s1;
	logic [NW:0]   sx_s1, sy_s1, sz_s1;
	logic [NW-1:0] qx_s1, qy_s1, qz_s1;
	logic [RW-1:0] ppz_s1;
	logic [DW-1:0] d_s1;
	// stage 2
	logic [RW-1:0] xp_s2, ep_s2, wp_s2, yz_s2, ynz_s2, ysz_s2;
	logic [PW-1:0] z_s2, zu_s2, zd_s2, ex_s2, ey_s2, ez_s2;
	logic [SW-1:0] cqx_s2, cqy_s2, cqz_s2, lsx_s2, lsy_s2, lsz_s2;
	logic [DW-1:0] d_s2;
	// stage 3
	logic [RW-1:0] nr_s3, sr_s3, er_s3, wr_s3, ur_s3, dr_s3;
	logic [SW-1:0] ofx_s3, ofy_s3, ofz_s3, lsx_s3, lsy_s3, lsz_s3;
	logic [DW-1:0] d_s3;
	// stage 4
	rsd_pkg::result_t res_s4;

	rsd_pkg::result_t obuf_q [rsd_pkg::OutDepth];
	logic [rsd_pkg::OutAw-1:0]   owp_q, orp_q;
	logic [rsd_pkg::OutCntW-1:0] ocnt_q;

	logic [RW-1:0] cqx_w, cqy_w, cqz_w;

	// credit toward the result buffer
	assign in_pop  = in_valid && (bocc_q < rsd_pkg::OutCntW'(rsd_pkg::OutDepth));
	assign deliver = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bocc_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
		end else begin
			bocc_q <= bocc_q + rsd_pkg::OutCntW'(in_pop) - rsd_pkg::OutCntW'(deliver);
			v_s1   <= in_pop;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
		end
	end

	// stage 1: wrapped coordinates, share terms, plane size
	always_ff @(posedge clk) begin
		x_s1  <= in_item.x;
		y_s1  <= in_item.y;
		z_s1  <= in_item.z;
		yn_s1 <= (in_item.y + 1'b1 == cfg.py) ? '0 : in_item.y + 1'b1;
		ys_s1 <= (in_item.y == '0) ? cfg.py - 1'b1 : in_item.y - 1'b1;
		zu_s1 <= (in_item.z + 1'b1 == cfg.pz) ? '0 : in_item.z + 1'b1;
		zd_s1 <= (in_item.z == '0) ? cfg.pz - 1'b1 : in_item.z - 1'b1;
		xe_s1 <= (in_item.xm + 1'b1 == cfg.px) ? '0 : in_item.xm + 1'b1;
		xw_s1 <= (in_item.xm == '0) ? cfg.px - 1'b1 : in_item.xm - 1'b1;
		ppz_s1 <= RW'(cfg.py) * RW'(cfg.pz);
		sx_s1 <= (NW+1)'(in_item.qx) + (NW+1)'(in_item.x < RW'(in_item.rx));
		sy_s1 <= (NW+1)'(in_item.qy) + (NW+1)'(in_item.y < in_item.ry);
		sz_s1 <= (NW+1)'(in_item.qz) + (NW+1)'(in_item.z < in_item.rz);
		ex_s1 <= (in_item.x < RW'(in_item.rx)) ? in_item.x[PW-1:0] : in_item.rx;
		ey_s1 <= (in_item.y < in_item.ry) ? in_item.y : in_item.ry;
		ez_s1 <= (in_item.z < in_item.rz) ? in_item.z : in_item.rz;
		qx_s1 <= in_item.qx;
		qy_s1 <= in_item.qy;
		qz_s1 <= in_item.qz;
		d_s1  <= in_item.d;
	end

	// coordinate times quotient, low bits only
	always_comb begin
		cqx_w = x_s1 * RW'(qx_s1);
		cqy_w = RW'(y_s1) * RW'(qy_s1);
		cqz_w = RW'(z_s1) * RW'(qz_s1);
	end

	// stage 2: products
	always_ff @(posedge clk) begin
		xp_s2  <= x_s1 * ppz_s1;
		ep_s2  <= RW'(xe_s1) * ppz_s1;
		wp_s2  <= RW'(xw_s1) * ppz_s1;
		yz_s2  <= RW'(y_s1) * RW'(cfg.pz);
		ynz_s2 <= RW'(yn_s1) * RW'(cfg.pz);
		ysz_s2 <= RW'(ys_s1) * RW'(cfg.pz);
		cqx_s2 <= cqx_w[SW-1:0];
		cqy_s2 <= cqy_w[SW-1:0];
		cqz_s2 <= cqz_w[SW-1:0];
		lsx_s2 <= SW'(sx_s1) * SW'(d_s1);
		lsy_s2 <= SW'(sy_s1) * SW'(d_s1);
		lsz_s2 <= SW'(sz_s1) * SW'(d_s1);
		z_s2   <= z_s1;
		zu_s2  <= zu_s1;
		zd_s2  <= zd_s1;
		ex_s2  <= ex_s1;
		ey_s2  <= ey_s1;
		ez_s2  <= ez_s1;
		d_s2   <= d_s1;
	end

	// stage 3: rank sums and unscaled offsets
	always_ff @(posedge clk) begin
		nr_s3  <= xp_s2 + ynz_s2 + RW'(z_s2);
		sr_s3  <= xp_s2 + ysz_s2 + RW'(z_s2);
		er_s3  <= ep_s2 + yz_s2 + RW'(z_s2);
		wr_s3  <= wp_s2 + yz_s2 + RW'(z_s2);
		ur_s3  <= xp_s2 + yz_s2 + RW'(zu_s2);
		dr_s3  <= xp_s2 + yz_s2 + RW'(zd_s2);
		ofx_s3 <= cqx_s2 + SW'(ex_s2);
		ofy_s3 <= cqy_s2 + SW'(ey_s2);
		ofz_s3 <= cqz_s2 + SW'(ez_s2);
		lsx_s3 <= lsx_s2;
		lsy_s3 <= lsy_s2;
		lsz_s3 <= lsz_s2;
		d_s3   <= d_s2;
	end

	// stage 4: offsets scaled by density
	always_ff @(posedge clk) begin
		res_s4.north_rank   <= nr_s3;
		res_s4.south_rank   <= sr_s3;
		res_s4.east_rank    <= er_s3;
		res_s4.west_rank    <= wr_s3;
		res_s4.up_rank      <= ur_s3;
		res_s4.down_rank    <= dr_s3;
		res_s4.local_size_x <= lsx_s3;
		res_s4.local_size_y <= lsy_s3;
		res_s4.local_size_z <= lsz_s3;
		res_s4.offset_x     <= ofx_s3 * SW'(d_s3);
		res_s4.offset_y     <= ofy_s3 * SW'(d_s3);
		res_s4.offset_z     <= ofz_s3 * SW'(d_s3);
	end

	// result buffer
	always_ff @(posedge clk) begin
		if (v_s4) begin
			obuf_q[owp_q] <= res_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= '0;
			orp_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (v_s4) begin
				owp_q <= owp_q + 1'b1;
			end
			if (deliver) begin
				orp_q <= orp_q + 1'b1;
			end
			ocnt_q <= ocnt_q + rsd_pkg::OutCntW'(v_s4) - rsd_pkg::OutCntW'(deliver);
		end
	end

	assign m_axis_tvalid = (ocnt_q != '0);
	assign m_axis_tdata  = {(rsd_pkg::OutDataW - rsd_pkg::ResW)'(0), obuf_q[orp_q]};

`ifndef ASSERT_OFF
	a_buf_room: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (ocnt_q < rsd_pkg::OutCntW'(rsd_pkg::OutDepth)) || deliver)
		else $error("result buffer written while full");
	a_credit_cover: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= bocc_q)
		else $error("buffered results exceed back credit count");
`endif

endmodule

`default_nettype wire

### sv/rank_subdomain_decomposer_unit.sv
// ---------------------------------------------------------------------------
// rank_subdomain_decomposer_unit: 3-D block decomposition of a processor rank
// Configuration registers, front classifier, item queue and back pipeline.
// ---------------------------------------------------------------------------
// Takes one rank per clock while the output keeps taking beats and returns one
// result per rank, in order. A rank is split into z, y and x by three chained
// pipelined dividers of eight stages each (two quotient bits per stage); after
// the front come the item queue, the back pipeline and the result buffer.
// The 32-entry queue and the 8-entry result buffer are what let the block keep
// one beat per cycle through the dividers and the back pipeline. Write
// registers only while idle.
// ---------------------------------------------------------------------------
`default_nettype none

module rank_subdomain_decomposer_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration writes
	input  wire logic                            cfg_we,
	input  wire logic [rsd_pkg::CfgIdxW-1:0]     cfg_index,
	input  wire logic [rsd_pkg::CfgW-1:0]        cfg_data,
	// input beats
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// proc_rank[15:0], density[19:16], zero pad
	input  wire logic [rsd_pkg::InDataW-1:0]     s_axis_tdata,
	// output beats
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// north_rank, south_rank, east_rank, west_rank, up_rank, down_rank (16 each),
	// local_size_x/y/z, offset_x/y/z (15 each), zero pad
	output logic [rsd_pkg::OutDataW-1:0]         m_axis_tdata
);

	logic [rsd_pkg::PtsW-1:0]  gpx_q, gpy_q, gpz_q;
	logic [rsd_pkg::ProcW-1:0] prx_q, pry_q, prz_q;
	rsd_pkg::cfg_t cfg;

	logic            push, pop, head_valid;
	rsd_pkg::coord_t push_item, head_item;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gpx_q <= rsd_pkg::PtsW'(1);
			gpy_q <= rsd_pkg::PtsW'(1);
			gpz_q <= rsd_pkg::PtsW'(1);
			prx_q <= rsd_pkg::ProcW'(1);
			pry_q <= rsd_pkg::ProcW'(1);
			prz_q <= rsd_pkg::ProcW'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				rsd_pkg::CFG_GPX: gpx_q <= cfg_data;
				rsd_pkg::CFG_GPY: gpy_q <= cfg_data;
				rsd_pkg::CFG_GPZ: gpz_q <= cfg_data;
				rsd_pkg::CFG_PX:  prx_q <= cfg_data[rsd_pkg::ProcW-1:0];
				rsd_pkg::CFG_PY:  pry_q <= cfg_data[rsd_pkg::ProcW-1:0];
				rsd_pkg::CFG_PZ:  prz_q <= cfg_data[rsd_pkg::ProcW-1:0];
				default: ;
			endcase
		end
	end

	// a zero processor count acts as one
	always_comb begin
		cfg.npx = gpx_q;
		cfg.npy = gpy_q;
		cfg.npz = gpz_q;
		cfg.px  = (prx_q == '0) ? rsd_pkg::ProcW'(1) : prx_q;
		cfg.py  = (pry_q == '0) ? rsd_pkg::ProcW'(1) : pry_q;
		cfg.pz  = (prz_q == '0) ? rsd_pkg::ProcW'(1) : prz_q;
	end

	rsd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_rank   (s_axis_tdata[rsd_pkg::RankW-1:0]),
		.in_dens   (s_axis_tdata[rsd_pkg::RankW +: rsd_pkg::DensW]),
		.push      (push),
		.push_item (push_item),
		.pop       (pop)
	);

	rsd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop)
	);

	rsd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (head_valid),
		.in_item       (head_item),
		.in_pop        (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// upper input pad bits carry nothing
	logic unused_pad;
	assign unused_pad = ^s_axis_tdata[rsd_pkg::InDataW-1:rsd_pkg::RankW+rsd_pkg::DensW];

endmodule

`default_nettype wire

### tb/rank_subdomain_decomposer_unit_test.sv
// ---------------------------------------------------------------------------
// rank_subdomain_decomposer_unit_test: self-checking bench of the decomposer
// Drives ranks and densities under several grid settings and compares each
// output beat against an in-bench model of the 3-D block decomposition.
// ---------------------------------------------------------------------------
`default_nettype none

module rank_subdomain_decomposer_unit_test;

	localparam int LatencyCycles = 40;
	localparam int CycleLimit = 400000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [rsd_pkg::CfgIdxW-1:0] cfg_index;
	logic [rsd_pkg::CfgW-1:0] cfg_data;
	logic s_axis_tvalid;
	logic s_axis_tready;
	// proc_rank[15:0], density[19:16], zero pad
	logic [rsd_pkg::InDataW-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	// north, south, east, west, up, down ranks, sizes x/y/z, offsets x/y/z, pad
	logic [rsd_pkg::OutDataW-1:0] m_axis_tdata;

	// shadow of the grid registers
	logic [rsd_pkg::PtsW-1:0] pts_x, pts_y, pts_z;
	logic [rsd_pkg::ProcW-1:0] procs_x, procs_y, procs_z;

	rsd_pkg::result_t decomp_q[$];
	int errors;
	longint cycles;
	bit hold_output;
	int gap_mode;

	rank_subdomain_decomposer_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("rank_subdomain_decomposer_unit test failed");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (gap_mode == 0) return 0;
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// share size and offset along one axis, wrapped to the output width
	function automatic logic [rsd_pkg::SizeW-1:0] share_len(longint c, longint n,
		longint p, longint d);
		longint s;
		s = n / p;
		if (c < n % p) s++;
		return rsd_pkg::SizeW'(s * d);
	endfunction

	function automatic logic [rsd_pkg::SizeW-1:0] share_start(longint c, longint n,
		longint p, longint d);
		longint rem;
		rem = n % p;
		return rsd_pkg::SizeW'((c * (n / p) + (c < rem ? c : rem)) * d);
	endfunction

	function automatic rsd_pkg::result_t decompose(logic [rsd_pkg::RankW-1:0] rank,
		logic [rsd_pkg::DensW-1:0] dens);
		longint px, py, pz, x, y, z, t;
		rsd_pkg::result_t res;
		px = (procs_x == 0) ? 1 : procs_x;
		py = (procs_y == 0) ? 1 : procs_y;
		pz = (procs_z == 0) ? 1 : procs_z;
		z = rank % pz;
		t = rank / pz;
		y = t % py;
		x = t / py;
		if (x >= px) x -= px;
		if (x >= px) x -= px;
		res.north_rank = rsd_pkg::RankW'(x * py * pz + ((y + 1) % py) * pz + z);
		res.south_rank = rsd_pkg::RankW'(x * py * pz + ((y + py - 1) % py) * pz + z);
		res.east_rank = rsd_pkg::RankW'(((x + 1) % px) * py * pz + y * pz + z);
		res.west_rank = rsd_pkg::RankW'(((x + px - 1) % px) * py * pz + y * pz + z);
		res.up_rank = rsd_pkg::RankW'(x * py * pz + y * pz + (z + 1) % pz);
		res.down_rank = rsd_pkg::RankW'(x * py * pz + y * pz + (z + pz - 1) % pz);
		res.local_size_x = share_len(x, pts_x, px, dens);
		res.local_size_y = share_len(y, pts_y, py, dens);
		res.local_size_z = share_len(z, pts_z, pz, dens);
		res.offset_x = share_start(x, pts_x, px, dens);
		res.offset_y = share_start(y, pts_y, py, dens);
		res.offset_z = share_start(z, pts_z, pz, dens);
		return res;
	endfunction

	task automatic write_reg(logic [rsd_pkg::CfgIdxW-1:0] idx,
		logic [rsd_pkg::CfgW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			rsd_pkg::CFG_GPX: pts_x = val;
			rsd_pkg::CFG_GPY: pts_y = val;
			rsd_pkg::CFG_GPZ: pts_z = val;
			rsd_pkg::CFG_PX: procs_x = val[rsd_pkg::ProcW-1:0];
			rsd_pkg::CFG_PY: procs_y = val[rsd_pkg::ProcW-1:0];
			rsd_pkg::CFG_PZ: procs_z = val[rsd_pkg::ProcW-1:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (decomp_q.size() != 0) @(posedge clk);
		repeat (LatencyCycles) @(posedge clk);
	endtask

	task automatic set_grid(int nx, int ny, int nz, int qx, int qy, int qz);
		drain();
		write_reg(rsd_pkg::CFG_GPX, rsd_pkg::CfgW'(nx));
		write_reg(rsd_pkg::CFG_GPY, rsd_pkg::CfgW'(ny));
		write_reg(rsd_pkg::CFG_GPZ, rsd_pkg::CfgW'(nz));
		write_reg(rsd_pkg::CFG_PX, rsd_pkg::CfgW'(qx));
		write_reg(rsd_pkg::CFG_PY, rsd_pkg::CfgW'(qy));
		write_reg(rsd_pkg::CFG_PZ, rsd_pkg::CfgW'(qz));
		cfg_we <= 1'b0;
	endtask

	// send one beat; the expectation is queued when it is accepted
	task automatic send_rank(logic [rsd_pkg::RankW-1:0] rank,
		logic [rsd_pkg::DensW-1:0] dens);
		int g;
		g = pick_gap();
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, dens, rank};
		do @(posedge clk); while (!s_axis_tready);
		decomp_q.push_back(decompose(rank, dens));
	endtask

	task automatic idle_input();
		s_axis_tvalid <= 1'b0;
	endtask

	// ranks per grid slot plus the ranks beyond the grid
	task automatic random_ranks(int count);
		int limit;
		limit = ((procs_x == 0) ? 1 : procs_x) * ((procs_y == 0) ? 1 : procs_y) *
			((procs_z == 0) ? 1 : procs_z);
		repeat (count) begin
			if ($urandom_range(0, 3) == 0 || limit > 65535)
				send_rank(rsd_pkg::RankW'($urandom()), rsd_pkg::DensW'($urandom()));
			else
				send_rank(rsd_pkg::RankW'($urandom_range(0, 3 * limit - 1)),
					rsd_pkg::DensW'($urandom_range(1, 8)));
		end
		idle_input();
	endtask

	task automatic test_reset_grid();
		send_rank(16'd0, 4'd1);
		send_rank(16'hffff, 4'hf);
		send_rank(16'd5, 4'd0);
		idle_input();
	endtask

	task automatic test_directed_cases();
		set_grid(10, 7, 13, 3, 2, 4);
		send_rank(16'd0, 4'd1);
		send_rank(16'd23, 4'd8);
		send_rank(16'd11, 4'd3);
		// beyond the grid once and twice, and still out of range
		send_rank(16'd30, 4'd2);
		send_rank(16'd55, 4'd2);
		send_rank(16'd90, 4'd5);
		send_rank(16'hffff, 4'hf);
		send_rank(16'd7, 4'd0);
		idle_input();
		// zero processor counts act as one, zero grid points
		set_grid(0, 4095, 0, 0, 0, 0);
		send_rank(16'd0, 4'd8);
		send_rank(16'd3, 4'd9);
		send_rank(16'h8000, 4'd4);
		idle_input();
		// largest grid point counts, overflowing ranks and sizes
		set_grid(4095, 4095, 4095, 256, 256, 256);
		send_rank(16'd0, 4'd8);
		send_rank(16'hffff, 4'hf);
		send_rank(16'h1234, 4'd7);
		idle_input();
		set_grid(4095, 1, 4095, 511, 1, 1);
		send_rank(16'd510, 4'd15);
		send_rank(16'd255, 4'd8);
		idle_input();
	endtask

	task automatic test_random_grids();
		for (int k = 0; k < 8; k++) begin
			if (k < 5)
				set_grid($urandom_range(0, 60), $urandom_range(0, 60),
					$urandom_range(0, 60), $urandom_range(0, 9),
					$urandom_range(0, 9), $urandom_range(0, 9));
			else
				set_grid($urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 4095), $urandom_range(0, 511),
					$urandom_range(0, 511), $urandom_range(0, 511));
			gap_mode = k % 3;
			random_ranks(45);
		end
		gap_mode = 1;
	endtask

	task automatic test_back_pressure();
		set_grid(37, 29, 41, 5, 3, 4);
		gap_mode = 0;
		hold_output = 1'b1;
		random_ranks(60);
		// sender pauses until all results are back
		drain();
		random_ranks(20);
		gap_mode = 1;
	endtask

	// output side: random stalls and one long hold-off
	initial begin
		int g;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_output) begin
				m_axis_tready <= 1'b0;
				repeat (150) @(posedge clk);
				hold_output = 1'b0;
			end
			g = pick_gap();
			if (g > 0) begin
				m_axis_tready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// result checker
	always @(posedge clk) begin
		rsd_pkg::result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[rsd_pkg::ResW-1:0];
			if (decomp_q.size() == 0) begin
				$display("%0t: unexpected beat, actual %h", $time, got);
				errors++;
			end else begin
				want = decomp_q.pop_front();
				if (got.north_rank !== want.north_rank)
					$display("%0t north_rank expected %h actual %h", $time,
						want.north_rank, got.north_rank);
				if (got.south_rank !== want.south_rank)
					$display("%0t south_rank expected %h actual %h", $time,
						want.south_rank, got.south_rank);
				if (got.east_rank !== want.east_rank)
					$display("%0t east_rank expected %h actual %h", $time,
						want.east_rank, got.east_rank);
				if (got.west_rank !== want.west_rank)
					$display("%0t west_rank expected %h actual %h", $time,
						want.west_rank, got.west_rank);
				if (got.up_rank !== want.up_rank)
					$display("%0t up_rank expected %h actual %h", $time,
						want.up_rank, got.up_rank);
				if (got.down_rank !== want.down_rank)
					$display("%0t down_rank expected %h actual %h", $time,
						want.down_rank, got.down_rank);
				if (got.local_size_x !== want.local_size_x)
					$display("%0t local_size_x expected %h actual %h", $time,
						want.local_size_x, got.local_size_x);
				if (got.local_size_y !== want.local_size_y)
					$display("%0t local_size_y expected %h actual %h", $time,
						want.local_size_y, got.local_size_y);
				if (got.local_size_z !== want.local_size_z)
					$display("%0t local_size_z expected %h actual %h", $time,
						want.local_size_z, got.local_size_z);
				if (got.offset_x !== want.offset_x)
					$display("%0t offset_x expected %h actual %h", $time,
						want.offset_x, got.offset_x);
				if (got.offset_y !== want.offset_y)
					$display("%0t offset_y expected %h actual %h", $time,
						want.offset_y, got.offset_y);
				if (got.offset_z !== want.offset_z)
					$display("%0t offset_z expected %h actual %h", $time,
						want.offset_z, got.offset_z);
				if (got !== want) errors++;
			end
		end
	end

	// test sequence
	initial begin
		errors = 0;
		cycles = 0;
		gap_mode = 1;
		hold_output = 1'b0;
		pts_x = 1; pts_y = 1; pts_z = 1;
		procs_x = 1; procs_y = 1; procs_z = 1;
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_grid();
		test_directed_cases();
		test_back_pressure();
		test_random_grids();
		drain();
		if (errors == 0)
			$display("rank_subdomain_decomposer_unit test passed");
		else
			$display("rank_subdomain_decomposer_unit test failed");
		$finish;
	end

endmodule

`default_nettype wire
